FILE: design/fde_pkg.sv
// fde_pkg: shared types and constants of the directory entry scanner
// no dependencies; used by fde_front, fde_queue, fde_back and the top level
package fde_pkg;

    // directory entry geometry
    localparam int ENTRY_BYTES   = 32;
    localparam int ENTRY_IDX_W   = 5;
    localparam int NAME_BYTES    = 8;
    localparam int EXT_BYTES     = 3;
    localparam int RAW_BYTES     = NAME_BYTES + EXT_BYTES;
    localparam int ATTR_IDX      = 11;
    localparam int CLUS_LO_IDX   = 26;
    localparam int CLUS_HI_IDX   = 27;
    localparam int SIZE_W        = 13;

    // register map
    localparam logic REG_SECTOR_BYTES = 1'b0;
    localparam logic [SIZE_W-1:0] SECTOR_BYTES_RESET = 13'd512;

    // byte codes
    localparam logic [7:0] CODE_FREE      = 8'h00;
    localparam logic [7:0] CODE_DELETED   = 8'hE5;
    localparam logic [7:0] CODE_ESC_E5    = 8'h05;
    localparam logic [7:0] CODE_DOT       = 8'h2E;
    localparam logic [7:0] CODE_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_CONCEALED = 8'h02;
    localparam logic [7:0] ATTR_SYSTEM    = 8'h04;
    localparam logic [7:0] ATTR_VOLUME    = 8'h08;
    localparam logic [7:0] ATTR_SUBDIR    = 8'h10;

    // one accepted entry, as handed from front to back
    typedef struct packed {
        logic [RAW_BYTES-1:0][7:0] raw;      // name bytes 0..7, extension 8..10
        logic [3:0]                fn_len;   // visible filename characters, 1..8
        logic [1:0]                ext_len;  // visible extension characters, 0..3
        logic [31:0]               epos;
        logic [15:0]               clus;
        logic                      subdir;
        logic                      descend;
    } fde_entry_t;

    // queue status toward its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } fde_q_status_t;

endpackage

FILE: design/fde_front.sv
// fde_front: gathers directory bytes into an entry, filters and classifies it
// depends on fde_pkg
module fde_front #(
    parameter int MAX_SECTOR_BYTES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [7:0]                  data_byte,
    input  logic [31:0]                 sector_position,
    input  logic [fde_pkg::SIZE_W-1:0]  sector_bytes,
    output logic                        push,
    output fde_pkg::fde_entry_t         entry
);

    localparam int CNT_W = $clog2(MAX_SECTOR_BYTES);
    localparam logic [fde_pkg::SIZE_W-1:0] MIN_SIZE = fde_pkg::SIZE_W'(fde_pkg::ENTRY_BYTES);
    localparam logic [fde_pkg::SIZE_W-1:0] MAX_SIZE = fde_pkg::SIZE_W'(MAX_SECTOR_BYTES);
    localparam logic [fde_pkg::ENTRY_IDX_W-1:0] LAST_IDX =
        fde_pkg::ENTRY_IDX_W'(fde_pkg::ENTRY_BYTES - 1);

    logic [CNT_W-1:0] off_reg;
    logic [CNT_W-1:0] off_next;
    logic [7:0]       name_reg [0:fde_pkg::ATTR_IDX];
    logic [7:0]       clus_lo_reg;
    logic [7:0]       clus_hi_reg;

    logic [fde_pkg::SIZE_W-1:0] size_eff;
    logic [fde_pkg::SIZE_W-1:0] off_ext;
    logic [fde_pkg::ENTRY_IDX_W-1:0] slot;
    logic [7:0] first;
    logic [7:0] attr;
    logic [7:0] fn [0:fde_pkg::NAME_BYTES-1];
    logic [3:0] fn_trim;
    logic [3:0] fn_zero;
    logic [1:0] ext_trim;
    logic [1:0] ext_zero;
    logic       keep;
    logic       complete;

    assign slot    = off_reg[fde_pkg::ENTRY_IDX_W-1:0];
    assign off_ext = fde_pkg::SIZE_W'(off_reg);

    // clamp the configured sector size
    always_comb
    begin
        if (sector_bytes < MIN_SIZE)
            size_eff = MIN_SIZE;
        else if (sector_bytes > MAX_SIZE)
            size_eff = MAX_SIZE;
        else
            size_eff = sector_bytes;
    end

    // byte offset within the sector
    always_comb
    begin
        if (off_ext + 13'd1 >= size_eff)
            off_next = '0;
        else
            off_next = off_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            off_reg <= '0;
        else if (accept)
            off_reg <= off_next;
    end

    // keep only the entry bytes that matter later
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (slot <= fde_pkg::ENTRY_IDX_W'(fde_pkg::ATTR_IDX))
                name_reg[slot[3:0]] <= data_byte;
            if (slot == fde_pkg::ENTRY_IDX_W'(fde_pkg::CLUS_LO_IDX))
                clus_lo_reg <= data_byte;
            if (slot == fde_pkg::ENTRY_IDX_W'(fde_pkg::CLUS_HI_IDX))
                clus_hi_reg <= data_byte;
        end
    end

    assign first = name_reg[0];
    assign attr  = name_reg[fde_pkg::ATTR_IDX];

    // visible lengths of filename and extension
    always_comb
    begin
        for (int i = 0; i < fde_pkg::NAME_BYTES; i++)
            fn[i] = name_reg[i];
        if (first == fde_pkg::CODE_ESC_E5)
            fn[0] = fde_pkg::CODE_DELETED;

        fn_trim = 4'd1;
        for (int i = 1; i < fde_pkg::NAME_BYTES; i++)
            if (fn[i] != fde_pkg::CODE_SPACE)
                fn_trim = 4'(i + 1);
        fn_zero = 4'(fde_pkg::NAME_BYTES);
        for (int i = fde_pkg::NAME_BYTES - 1; i >= 0; i--)
            if (fn[i] == 8'h00)
                fn_zero = 4'(i);

        ext_trim = 2'd0;
        for (int i = 0; i < fde_pkg::EXT_BYTES; i++)
            if (name_reg[fde_pkg::NAME_BYTES + i] != fde_pkg::CODE_SPACE)
                ext_trim = 2'(i + 1);
        ext_zero = 2'(fde_pkg::EXT_BYTES);
        for (int i = fde_pkg::EXT_BYTES - 1; i >= 0; i--)
            if (name_reg[fde_pkg::NAME_BYTES + i] == 8'h00)
                ext_zero = 2'(i);
    end

    // filter on first byte and attributes
    assign keep = (first != fde_pkg::CODE_FREE) && (first != fde_pkg::CODE_DELETED)
                  && ((attr & (fde_pkg::ATTR_CONCEALED | fde_pkg::ATTR_SYSTEM
                               | fde_pkg::ATTR_VOLUME)) == 8'h00);
    assign complete = accept && (slot == LAST_IDX) && (off_ext < size_eff);
    assign push     = complete && keep;

    // descriptor for the back end
    always_comb
    begin
        for (int i = 0; i < fde_pkg::NAME_BYTES; i++)
            entry.raw[i] = fn[i];
        for (int i = 0; i < fde_pkg::EXT_BYTES; i++)
            entry.raw[fde_pkg::NAME_BYTES + i] = name_reg[fde_pkg::NAME_BYTES + i];
        entry.fn_len  = (fn_trim < fn_zero) ? fn_trim : fn_zero;
        entry.ext_len = (ext_trim < ext_zero) ? ext_trim : ext_zero;
        entry.epos    = sector_position
                        + 32'({off_reg[CNT_W-1:fde_pkg::ENTRY_IDX_W],
                               {fde_pkg::ENTRY_IDX_W{1'b0}}});
        entry.clus    = {clus_hi_reg, clus_lo_reg};
        entry.subdir  = (first == fde_pkg::CODE_DOT) || ((attr & fde_pkg::ATTR_SUBDIR) != 8'h00);
        entry.descend = entry.subdir && (name_reg[1] != fde_pkg::CODE_DOT);
    end

endmodule

FILE: design/fde_queue.sv
// fde_queue: short first-in first-out queue of entry descriptors
// depends on fde_pkg
module fde_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fde_pkg::fde_entry_t  push_data,
    input  logic                 pop,
    output fde_pkg::fde_entry_t  head,
    output fde_pkg::fde_q_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    fde_pkg::fde_entry_t slots_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == (PTR_W + 1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: design/fde_back.sv
// fde_back: walks one entry descriptor and emits its name one character per item
// depends on fde_pkg
module fde_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fde_pkg::fde_entry_t    head,
    input  fde_pkg::fde_q_status_t q_status,
    output logic                   pop,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [7:0]             name_char,
    output logic                   last_char,
    output logic [31:0]            entry_position,
    output logic [15:0]            start_cluster,
    output logic                   is_subdir,
    output logic                   descend
);

    fde_pkg::fde_entry_t cur_reg;
    logic        busy_reg;
    logic [3:0]  idx_reg;
    logic        ov_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic [31:0] epos_reg;
    logic [15:0] clus_reg;
    logic        subdir_reg;
    logic        descend_reg;

    logic [3:0] total;
    logic [3:0] ext_off;
    logic [7:0] char_sel;
    logic       is_last;
    logic       emit;

    // characters in this name: filename, then dot and extension if present
    assign total   = cur_reg.fn_len
                     + ((cur_reg.ext_len != 2'd0) ? (4'(cur_reg.ext_len) + 4'd1) : 4'd0);
    assign is_last = (idx_reg == total - 4'd1);
    assign ext_off = idx_reg - cur_reg.fn_len - 4'd1;
    assign emit    = busy_reg && (!ov_reg || out_ready);
    assign pop     = !busy_reg && !q_status.empty;

    // character select
    always_comb
    begin
        priority if (idx_reg < cur_reg.fn_len)
            char_sel = cur_reg.raw[idx_reg[2:0]];
        else if (idx_reg == cur_reg.fn_len)
            char_sel = fde_pkg::CODE_DOT;
        else
            char_sel = cur_reg.raw[fde_pkg::NAME_BYTES + int'(ext_off[1:0])];
    end

    // control: current entry and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 4'd1;
                if (is_last)
                    busy_reg <= 1'b0;
            end

            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload; the whole item is held in the output register while it waits
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (emit)
        begin
            char_reg    <= char_sel;
            last_reg    <= is_last;
            epos_reg    <= cur_reg.epos;
            clus_reg    <= cur_reg.clus;
            subdir_reg  <= cur_reg.subdir;
            descend_reg <= cur_reg.descend;
        end
    end

    assign out_valid      = ov_reg;
    assign name_char      = char_reg;
    assign last_char      = last_reg;
    assign entry_position = epos_reg;
    assign start_cluster  = clus_reg;
    assign is_subdir      = subdir_reg;
    assign descend        = descend_reg;

endmodule

FILE: design/fat_directory_entry_scanner.sv
// fat_directory_entry_scanner: top level, config register and front/queue/back
// depends on fde_pkg, fde_front, fde_queue, fde_back
// one byte per cycle is taken while the entry queue has room; while out_ready is
// high, name characters leave one per cycle from an output register, each entry
// via a queue slot and the back end's entry register, and an entry holds the back
// end less than its 32 bytes take, so a two-deep queue keeps input at full rate
// reset clears counters, queue and output valid; sector_bytes resets to 512
module fat_directory_entry_scanner #(
    parameter int MAX_SECTOR_BYTES = 4096,
    parameter int QUEUE_DEPTH      = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic [31:0] sector_position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  name_char,
    output logic        last_char,
    output logic [31:0] entry_position,
    output logic [15:0] start_cluster,
    output logic        is_subdir,
    output logic        descend
);

    logic [fde_pkg::SIZE_W-1:0] sector_bytes_reg;
    logic                       cfg_write;
    logic                       accept;
    logic                       q_push;
    logic                       q_pop;
    fde_pkg::fde_entry_t        q_in;
    fde_pkg::fde_entry_t        q_head;
    fde_pkg::fde_q_status_t     q_status;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == fde_pkg::REG_SECTOR_BYTES);
    assign prdata    = (paddr[2] == fde_pkg::REG_SECTOR_BYTES)
                       ? 32'(sector_bytes_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sector_bytes_reg <= fde_pkg::SECTOR_BYTES_RESET;
        else if (cfg_write)
            sector_bytes_reg <= pwdata[fde_pkg::SIZE_W-1:0];
    end

    // input handshake
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    fde_front #(
        .MAX_SECTOR_BYTES(MAX_SECTOR_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .sector_position (sector_position),
        .sector_bytes    (sector_bytes_reg),
        .push            (q_push),
        .entry           (q_in)
    );

    fde_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    fde_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .q_status       (q_status),
        .pop            (q_pop),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .name_char      (name_char),
        .last_char      (last_char),
        .entry_position (entry_position),
        .start_cluster  (start_cluster),
        .is_subdir      (is_subdir),
        .descend        (descend)
    );

    // an entry is never pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("entry pushed into full queue");

    // queue cannot report full and empty together
    a_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    // a taken character that is not the last is followed at once by the next
    a_name_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_char) |=> out_valid)
        else $error("gap inside a name");

endmodule
